>>> hdl/v3a_pkg.sv
// Package for the three-component vector ALU.
// Holds the operation codes, the lane result word, pipeline latencies and saturation.
// No dependencies.
package v3a_pkg;

	typedef enum logic [2:0] {
		FN_ADD   = 3'd0,
		FN_SUB   = 3'd1,
		FN_SCALE = 3'd2,
		FN_DOT   = 3'd3,
		FN_CROSS = 3'd4,
		FN_LERP  = 3'd5,
		FN_NORM  = 3'd6,
		FN_RANGE = 3'd7
	} func_t;

	localparam logic signed [32:0] Q_ONE       = 33'sd65536;
	localparam logic [63:0]        TINY_MAG_SQ = 64'd43;
	localparam int                 SQRT_LAT    = 37;
	localparam int                 DIV_LAT     = 34;

	typedef struct packed {
		logic signed [63:0] val;
		logic               far;
	} lane_out_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/vector3_alu.sv
// Three-component Q16.16 vector ALU, top level: input stage, three lanes, merge,
// normalize path (root and per-lane dividers), output register. Depends on v3a_pkg.
// Throughput: one word per cycle; busy is never raised and the result side cannot stall.
// The depth is set by the normalize path: 5 shift stages, 32 root stages, 34 divide stages.
// Reset clears all valid bits; no result is strobed until a word is accepted after reset.
module vector3_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         func,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] scalar_in,
	output logic               done,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z,
	output logic signed [31:0] res_scalar,
	output logic               res_flag
);
	import v3a_pkg::*;

	localparam int FAST_LAT = SQRT_LAT + DIV_LAT;

	logic               v_s1, v_s2, v_s3, v_s4;
	func_t              func_s1, func_s2, func_s3;
	logic signed [31:0] a_s1 [3];
	logic signed [31:0] b_s1 [3];
	logic signed [31:0] a_s2 [3];
	logic signed [31:0] a_s3 [3];
	logic signed [31:0] s_s1;
	logic signed [63:0] rm2_s2, rm2_s3;
	logic signed [31:0] c [3][4];
	lane_out_t          lo [3];

	logic signed [65:0] sum3;
	logic [63:0]        msum;
	logic               any_far;

	logic signed [31:0] rv_s4 [3];
	logic signed [31:0] sc_s4;
	logic               flag_s4, norm_s4;
	logic [63:0]        m_s4;
	logic [31:0]        mag_s4 [3];
	logic [2:0]         neg_s4;

	logic [31:0]        root;
	logic [4:0]         kk;
	logic [95:0]        mag_d;
	logic [132:0]       fast_d;
	logic               v_d;
	logic [32:0]        qd [3];
	logic signed [31:0] nres [3];

	logic               done_q, flag_q;
	logic signed [31:0] rx_q, ry_q, rz_q, sc_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func_t'(func);
		a_s1[0] <= a_x;
		a_s1[1] <= a_y;
		a_s1[2] <= a_z;
		b_s1[0] <= b_x;
		b_s1[1] <= b_y;
		b_s1[2] <= b_z;
		s_s1    <= scalar_in;
		func_s2 <= func_s1;
		func_s3 <= func_s2;
		a_s2    <= a_s1;
		a_s3    <= a_s2;
		rm2_s2  <= s_s1 * s_s1;
		rm2_s3  <= rm2_s2;
	end

	always_comb begin
		c[0][0] = a_s1[1];
		c[0][1] = b_s1[2];
		c[0][2] = a_s1[2];
		c[0][3] = b_s1[1];
		c[1][0] = a_s1[2];
		c[1][1] = b_s1[0];
		c[1][2] = a_s1[0];
		c[1][3] = b_s1[2];
		c[2][0] = a_s1[0];
		c[2][1] = b_s1[1];
		c[2][2] = a_s1[1];
		c[2][3] = b_s1[0];
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		v3a_lane u_lane (
			.clk      (clk),
			.func     (func_s1),
			.a        (a_s1[i]),
			.b        (b_s1[i]),
			.s        (s_s1),
			.c0       (c[i][0]),
			.c1       (c[i][1]),
			.c2       (c[i][2]),
			.c3       (c[i][3]),
			.lane_out (lo[i])
		);
	end

	always_comb begin
		sum3    = 66'(lo[0].val) + 66'(lo[1].val) + 66'(lo[2].val);
		msum    = lo[0].val[63:0] + lo[1].val[63:0] + lo[2].val[63:0];
		any_far = lo[0].far | lo[1].far | lo[2].far;
	end

	always_ff @(posedge clk) begin
		m_s4    <= msum;
		sc_s4   <= (func_s3 == FN_DOT) ? sat32(sum3) : 32'sd0;
		flag_s4 <= (func_s3 == FN_RANGE) && !any_far && (msum <= 64'(rm2_s3));
		norm_s4 <= (func_s3 == FN_NORM) && (msum >= TINY_MAG_SQ);
		for (int i = 0; i < 3; i++) begin
			mag_s4[i] <= a_s3[i][31] ? 32'(-33'(a_s3[i])) : a_s3[i];
			neg_s4[i] <= a_s3[i][31];
			case (func_s3)
				FN_DOT, FN_RANGE: rv_s4[i] <= '0;
				FN_NORM:          rv_s4[i] <= a_s3[i];
				default:          rv_s4[i] <= sat32(66'(lo[i].val));
			endcase
		end
	end

	v3a_sqrt u_sqrt (
		.clk  (clk),
		.m    (m_s4),
		.root (root),
		.k    (kk)
	);

	v3a_delay #(.W(96), .N(SQRT_LAT)) u_mag_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    ({mag_s4[2], mag_s4[1], mag_s4[0]}),
		.dout   (mag_d)
	);

	v3a_delay #(.W(133), .N(FAST_LAT)) u_fast_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    ({neg_s4, norm_s4, flag_s4, sc_s4, rv_s4[2], rv_s4[1], rv_s4[0]}),
		.dout   (fast_d)
	);

	v3a_delay #(.W(1), .N(FAST_LAT)) u_vld_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (v_s4),
		.dout   (v_d)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		v3a_div u_div (
			.clk  (clk),
			.mag  (mag_d[32*i +: 32]),
			.k    (kk),
			.root (root),
			.q    (qd[i])
		);
		always_comb begin
			if (qd[i] >= 33'h0_8000_0000) begin
				nres[i] = fast_d[130+i] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				nres[i] = fast_d[130+i] ? -$signed(qd[i][31:0]) : $signed(qd[i][31:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		rx_q   <= fast_d[129] ? nres[0] : $signed(fast_d[31:0]);
		ry_q   <= fast_d[129] ? nres[1] : $signed(fast_d[63:32]);
		rz_q   <= fast_d[129] ? nres[2] : $signed(fast_d[95:64]);
		sc_q   <= $signed(fast_d[127:96]);
		flag_q <= fast_d[128];
	end

	assign done       = done_q;
	assign res_x      = rx_q;
	assign res_y      = ry_q;
	assign res_z      = rz_q;
	assign res_scalar = sc_q;
	assign res_flag   = flag_q;

endmodule

>>> hdl/v3a_delay.sv
// Fixed-length register delay line.
// Standalone; no package needed.
module v3a_delay #(
	parameter int W = 8,
	parameter int N = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) sr_q[i] <= '0;
		end else begin
			sr_q[0] <= din;
			for (int i = 1; i < N; i++) sr_q[i] <= sr_q[i-1];
		end
	end

	assign dout = sr_q[N-1];

endmodule

>>> hdl/v3a_lane.sv
// One component lane: operand select, two multipliers, per-operation combine.
// Depends on v3a_pkg.
module v3a_lane (
	input  logic               clk,
	input  v3a_pkg::func_t     func,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic signed [31:0] s,
	input  logic signed [31:0] c0,
	input  logic signed [31:0] c1,
	input  logic signed [31:0] c2,
	input  logic signed [31:0] c3,
	output v3a_pkg::lane_out_t lane_out
);
	import v3a_pkg::*;

	logic signed [32:0] a33, b33, tw, d, pa, pb, qa, qb, sum;
	logic               far;
	logic signed [65:0] p_s2, q_s2;
	logic signed [32:0] sum_s2;
	logic               far_s2;
	func_t              func_s2;
	lane_out_t          out_s3;

	always_comb begin
		a33 = {a[31], a};
		b33 = {b[31], b};
		d   = a33 - b33;
		far = d[32] ? (d < -33'sd2147483648) : (d > 33'sd2147483648);
		sum = (func == FN_SUB) ? d : a33 + b33;
		if (s > 32'sd65536) begin
			tw = Q_ONE;
		end else if (s < 32'sd0) begin
			tw = '0;
		end else begin
			tw = {s[31], s};
		end
		pa = '0;
		pb = '0;
		qa = '0;
		qb = '0;
		case (func)
			FN_SCALE: begin
				pa = a33;
				pb = {s[31], s};
			end
			FN_DOT: begin
				pa = a33;
				pb = b33;
			end
			FN_CROSS: begin
				pa = {c0[31], c0};
				pb = {c1[31], c1};
				qa = {c2[31], c2};
				qb = {c3[31], c3};
			end
			FN_LERP: begin
				pa = a33;
				pb = Q_ONE - tw;
				qa = b33;
				qb = tw;
			end
			FN_NORM: begin
				pa = a33;
				pb = a33;
			end
			FN_RANGE: begin
				pa = d;
				pb = d;
			end
			default: begin
				pa = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_s2    <= pa * pb;
		q_s2    <= qa * qb;
		sum_s2  <= sum;
		far_s2  <= far;
		func_s2 <= func;
	end

	always_ff @(posedge clk) begin
		out_s3.far <= far_s2;
		case (func_s2)
			FN_ADD, FN_SUB:   out_s3.val <= 64'(sum_s2);
			FN_SCALE, FN_DOT: out_s3.val <= 64'(p_s2 >>> 16);
			FN_CROSS:         out_s3.val <= 64'((p_s2 >>> 16) - (q_s2 >>> 16));
			FN_LERP:          out_s3.val <= 64'((p_s2 + q_s2) >>> 16);
			FN_NORM:          out_s3.val <= 64'(p_s2);
			default:          out_s3.val <= far_s2 ? 64'sd0 : 64'(p_s2);
		endcase
	end

	assign lane_out = out_s3;

endmodule

>>> hdl/v3a_sqrt.sv
// Pipelined magnitude root: even left shift to at least 2^60, then bitwise integer root.
// No package needed.
module v3a_sqrt (
	input  logic        clk,
	input  logic [63:0] m,
	output logic [31:0] root,
	output logic [4:0]  k
);

	localparam int NSTEP = 5;
	localparam int NIT   = 32;

	logic [63:0] mn_q [NSTEP];
	logic [4:0]  kn_q [NSTEP];
	logic [63:0] rn_q [NIT];
	logic [63:0] rr_q [NIT];
	logic [4:0]  rk_q [NIT];

	for (genvar j = 0; j < NSTEP; j++) begin : g_shift
		localparam int          STEP = 16 >> j;
		localparam logic [63:0] LIM  = 64'd1 << (62 - 2 * STEP);
		logic [63:0] src_m;
		logic [4:0]  src_k;
		if (j == 0) begin : g_first
			assign src_m = m;
			assign src_k = '0;
		end else begin : g_next
			assign src_m = mn_q[j-1];
			assign src_k = kn_q[j-1];
		end
		always_ff @(posedge clk) begin
			if (src_m < LIM) begin
				mn_q[j] <= src_m << (2 * STEP);
				kn_q[j] <= src_k | 5'(STEP);
			end else begin
				mn_q[j] <= src_m;
				kn_q[j] <= src_k;
			end
		end
	end

	for (genvar i = 0; i < NIT; i++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] src_n, src_r, trial;
		logic [4:0]  src_k;
		if (i == 0) begin : g_first
			assign src_n = mn_q[NSTEP-1];
			assign src_r = '0;
			assign src_k = kn_q[NSTEP-1];
		end else begin : g_next
			assign src_n = rn_q[i-1];
			assign src_r = rr_q[i-1];
			assign src_k = rk_q[i-1];
		end
		assign trial = src_r + BIT;
		always_ff @(posedge clk) begin
			rk_q[i] <= src_k;
			if (src_n >= trial) begin
				rn_q[i] <= src_n - trial;
				rr_q[i] <= (src_r >> 1) + BIT;
			end else begin
				rn_q[i] <= src_n;
				rr_q[i] <= src_r >> 1;
			end
		end
	end

	assign root = rr_q[NIT-1][31:0];
	assign k    = rk_q[NIT-1];

endmodule

>>> hdl/v3a_div.sv
// Pipelined restoring divider, one quotient bit per stage: (mag << (32+k)) / root.
// No package needed.
module v3a_div (
	input  logic        clk,
	input  logic [31:0] mag,
	input  logic [4:0]  k,
	input  logic [31:0] root,
	output logic [32:0] q
);

	localparam int QB = 33;

	logic [91:0] num;
	logic [31:0] r0_q, d0_q;
	logic [32:0] nlo0_q;
	logic [31:0] r_q   [QB];
	logic [31:0] d_q   [QB];
	logic [32:0] nlo_q [QB];
	logic [32:0] qq_q  [QB];

	assign num = {60'd0, mag} << (7'd32 + 7'(k));

	always_ff @(posedge clk) begin
		r0_q   <= num[64:33];
		nlo0_q <= num[32:0];
		d0_q   <= root;
	end

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [31:0] src_r, src_d;
		logic [32:0] src_n, src_q, t;
		logic        ge;
		if (i == 0) begin : g_first
			assign src_r = r0_q;
			assign src_d = d0_q;
			assign src_n = nlo0_q;
			assign src_q = '0;
		end else begin : g_next
			assign src_r = r_q[i-1];
			assign src_d = d_q[i-1];
			assign src_n = nlo_q[i-1];
			assign src_q = qq_q[i-1];
		end
		assign t  = {src_r, src_n[QB-1-i]};
		assign ge = t >= {1'b0, src_d};
		always_ff @(posedge clk) begin
			r_q[i]   <= ge ? 32'(t - {1'b0, src_d}) : t[31:0];
			d_q[i]   <= src_d;
			nlo_q[i] <= src_n;
			qq_q[i]  <= {src_q[31:0], ge};
		end
	end

	assign q = qq_q[QB-1];

endmodule

>>> tb/sv/tb.sv
// Testbench for vector3_alu: directed table of words, then random bursts,
// every result checked against the table's fixed expected value or a bit-exact predictor in this file.
// Depends on v3a_pkg (operation codes) and the vector3_alu RTL.
`timescale 1ns / 100ps

module tb;
	import v3a_pkg::*;

	localparam int N_RANDOM = 1930;
	localparam int WDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [2:0]         fn;
		logic signed [31:0] ax, ay, az, bx, by, bz, s;
	} vec_word_t;

	typedef struct {
		logic signed [31:0] x, y, z, sc;
		logic               flag;
	} vec_res_t;

	typedef struct {
		vec_word_t w;
		bit        fixed;
		vec_res_t  r;
	} table_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         func;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scalar_in;
	logic               done;
	logic signed [31:0] res_x, res_y, res_z, res_scalar;
	logic               res_flag;

	vec_res_t  pending_q[$];
	int        n_fail;
	int        idle_cycles;
	bit        timed_out;

	vector3_alu i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.scalar_in(scalar_in), .done(done), .res_x(res_x), .res_y(res_y),
		.res_z(res_z), .res_scalar(res_scalar), .res_flag(res_flag)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -128'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [127:0] mul_floor(input logic signed [127:0] p, q);
		logic signed [127:0] prod;
		prod = p * q;
		return prod >>> 16;
	endfunction

	function automatic logic [127:0] root_floor(input logic [127:0] n);
		logic [127:0] res, bitv;
		res = 0;
		bitv = 128'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic vec_res_t vector_result(input vec_word_t w);
		vec_res_t r;
		logic signed [127:0] a[3], b[3], v[3], s, t, dsc;
		logic [127:0] m, rt, q, d, d2, mg[3];
		int k;
		bit far_off;
		a[0] = w.ax; a[1] = w.ay; a[2] = w.az;
		b[0] = w.bx; b[1] = w.by; b[2] = w.bz;
		s = w.s;
		v[0] = 0; v[1] = 0; v[2] = 0;
		dsc = 0;
		r.flag = 1'b0;
		case (func_t'(w.fn))
			FN_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
			FN_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
			FN_SCALE: for (int i = 0; i < 3; i++) v[i] = mul_floor(a[i], s);
			FN_DOT: dsc = mul_floor(a[0], b[0]) + mul_floor(a[1], b[1])
				+ mul_floor(a[2], b[2]);
			FN_CROSS: begin
				v[0] = mul_floor(a[1], b[2]) - mul_floor(a[2], b[1]);
				v[1] = mul_floor(a[2], b[0]) - mul_floor(a[0], b[2]);
				v[2] = mul_floor(a[0], b[1]) - mul_floor(a[1], b[0]);
			end
			FN_LERP: begin
				t = s;
				if (t > 65536) t = 65536;
				if (t < 0) t = 0;
				for (int i = 0; i < 3; i++)
					v[i] = (a[i] * (65536 - t) + b[i] * t) >>> 16;
			end
			FN_NORM: begin
				m = 0;
				for (int i = 0; i < 3; i++) begin
					mg[i] = (a[i] < 0) ? -a[i] : a[i];
					m = m + mg[i] * mg[i];
				end
				if (m < 43) begin
					for (int i = 0; i < 3; i++) v[i] = a[i];
				end else begin
					k = 0;
					while (m < (128'd1 << 60)) begin
						m = m << 2;
						k++;
					end
					rt = root_floor(m);
					for (int i = 0; i < 3; i++) begin
						q = (mg[i] << (32 + k)) / rt;
						if (q > 128'h8000_0000) q = 128'h8000_0000;
						v[i] = (a[i] < 0) ? -$signed(q) : $signed(q);
					end
				end
			end
			default: begin
				d2 = 0;
				far_off = 0;
				for (int i = 0; i < 3; i++) begin
					d = (a[i] - b[i] < 0) ? b[i] - a[i] : a[i] - b[i];
					if (d > 128'h8000_0000) far_off = 1;
					else d2 = d2 + d * d;
				end
				m = (s < 0) ? -s : s;
				r.flag = (!far_off && d2 <= m * m);
			end
		endcase
		r.x = clip32(v[0]);
		r.y = clip32(v[1]);
		r.z = clip32(v[2]);
		r.sc = clip32(dsc);
		return r;
	endfunction

	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $urandom;
			4: return $signed($urandom_range(0, 200)) - 100;
			default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
		endcase
	endfunction

	function automatic vec_word_t rand_word();
		vec_word_t w;
		w.fn = 3'($urandom_range(0, 7));
		w.ax = rand_comp(); w.ay = rand_comp(); w.az = rand_comp();
		w.bx = rand_comp(); w.by = rand_comp(); w.bz = rand_comp();
		w.s = rand_comp();
		if (w.fn == FN_LERP && $urandom_range(0, 1))
			w.s = $signed($urandom_range(0, 70000)) - 2000;
		if (w.fn == FN_RANGE && $urandom_range(0, 1)) begin
			w.bx = w.ax + ($signed($urandom_range(0, 2000)) - 1000);
			w.by = w.ay + ($signed($urandom_range(0, 2000)) - 1000);
			w.bz = w.az + ($signed($urandom_range(0, 2000)) - 1000);
			w.s = $urandom_range(0, 1800);
		end
		return w;
	endfunction

	task automatic send_word(input vec_word_t w);
		start <= 1'b1;
		func <= w.fn;
		a_x <= w.ax; a_y <= w.ay; a_z <= w.az;
		b_x <= w.bx; b_y <= w.by; b_z <= w.bz;
		scalar_in <= w.s;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_and_predict(input vec_word_t w, input bit fixed, input vec_res_t r);
		if (fixed) pending_q.push_back(r);
		else pending_q.push_back(vector_result(w));
		send_word(w);
	endtask

	task automatic hold_gap();
		start <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	always @(posedge clk) begin
		vec_res_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$error("result with nothing pending");
				n_fail++;
			end else begin
				e = pending_q.pop_front();
				if (res_x !== e.x) begin
					$error("res_x exp %h got %h", e.x, res_x); n_fail++;
				end
				if (res_y !== e.y) begin
					$error("res_y exp %h got %h", e.y, res_y); n_fail++;
				end
				if (res_z !== e.z) begin
					$error("res_z exp %h got %h", e.z, res_z); n_fail++;
				end
				if (res_scalar !== e.sc) begin
					$error("res_scalar exp %h got %h", e.sc, res_scalar); n_fail++;
				end
				if (res_flag !== e.flag) begin
					$error("res_flag exp %b got %b", e.flag, res_flag); n_fail++;
				end
			end
		end
	end

	// watchdog: count cycles with nothing moving on either side
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	table_row_t dir_table[] = '{
		'{'{FN_ADD, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{FN_ADD, MAXV, MINV, 1, 1, -1, 2, 0}, 1, '{MAXV, MINV, 3, 0, 0}},
		'{'{FN_SUB, MINV, MAXV, 5, 1, -1, 2, 0}, 1, '{MINV, MAXV, 3, 0, 0}},
		'{'{FN_SCALE, ONE, -ONE, MAXV, 0, 0, 0, ONE}, 1, '{ONE, -ONE, MAXV, 0, 0}},
		'{'{FN_SCALE, MAXV, MINV, 7, 0, 0, 0, MAXV}, 0, '{0, 0, 0, 0, 0}},
		'{'{FN_DOT, ONE, ONE, ONE, ONE, ONE, ONE, 0}, 1, '{0, 0, 0, 3 * ONE, 0}},
		'{'{FN_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0}, 1, '{0, 0, 0, MAXV, 0}},
		'{'{FN_DOT, MINV, MINV, MINV, MAXV, MAXV, MAXV, 0}, 1, '{0, 0, 0, MINV, 0}},
		'{'{FN_CROSS, ONE, 0, 0, 0, ONE, 0, 0}, 1, '{0, 0, ONE, 0, 0}},
		'{'{FN_CROSS, MINV, MAXV, MINV, MAXV, MINV, MAXV, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{FN_LERP, ONE, 2, 3, 0, 0, 0, -5}, 1, '{ONE, 2, 3, 0, 0}},
		'{'{FN_LERP, ONE, 2, 3, 7, 8, 9, MAXV}, 1, '{7, 8, 9, 0, 0}},
		'{'{FN_LERP, MINV, MAXV, 0, MAXV, MINV, ONE, ONE / 2}, 0, '{0, 0, 0, 0, 0}},
		'{'{FN_NORM, 3 * ONE, 0, 0, 0, 0, 0, 0}, 1, '{MAXV, 0, 0, 0, 0}},
		'{'{FN_NORM, 6, -1, 0, 0, 0, 0, 0}, 1, '{6, -1, 0, 0, 0}},
		'{'{FN_NORM, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{FN_NORM, 7, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{FN_NORM, MINV, MINV, MINV, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{FN_NORM, 0, MINV, 0, 0, 0, 0, 0}, 1, '{0, MINV, 0, 0, 0}},
		'{'{FN_RANGE, 0, 0, 0, 3, 4, 0, 5}, 1, '{0, 0, 0, 0, 1}},
		'{'{FN_RANGE, 0, 0, 0, 3, 4, 0, -4}, 1, '{0, 0, 0, 0, 0}},
		'{'{FN_RANGE, MINV, 0, 0, MAXV, 0, 0, MINV}, 1, '{0, 0, 0, 0, 0}},
		'{'{FN_RANGE, MINV, 0, 0, 0, 0, 0, MINV}, 1, '{0, 0, 0, 0, 1}}
	};

	initial begin
		vec_res_t none;
		int burst;
		arst_n = 1'b0;
		start = 1'b0;
		func = '0;
		{a_x, a_y, a_z, b_x, b_y, b_z, scalar_in} = '0;
		none = '{0, 0, 0, 0, 0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_table[i]) begin
			send_and_predict(dir_table[i].w, dir_table[i].fixed, dir_table[i].r);
			if ($urandom_range(0, 3) == 0) hold_gap();
		end
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int j = 0; j < burst && n < N_RANDOM; j++, n++)
				send_and_predict(rand_word(), 0, none);
			if ($urandom_range(0, 2) != 0) hold_gap();
		end
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hdl/v3a_pkg.sv
hdl/v3a_delay.sv
hdl/v3a_lane.sv
hdl/v3a_sqrt.sv
hdl/v3a_div.sv
hdl/vector3_alu.sv
tb/sv/tb.sv
